[hdl/lz77td_pkg.sv]
// ----------------------------------------------------------------------------
// lz77td_pkg
// Shared constants and types of the lz77 token decoder: history geometry,
// result packing and the byte group handed from the copy engine to the
// output stage.
// ----------------------------------------------------------------------------
package lz77td_pkg;

  // history window, a power of two so pointers wrap by truncation
  localparam int unsigned HistDepth = 32768;
  localparam int unsigned HistAw    = $clog2(HistDepth);

  // result packing
  localparam int unsigned ByteFields     = 8;
  localparam int unsigned ByteIdxW       = $clog2(ByteFields);
  localparam int unsigned BytesPerResult = 8;
  localparam int unsigned CntW           = 4;

  // token field widths
  localparam int unsigned DistW = 15;
  localparam int unsigned LenW  = 9;

  // match length is the code plus this base
  localparam logic [LenW-1:0] MatchBase = LenW'(3);

  typedef logic [7:0] byte_t;

  // byte group ready for the output register
  typedef struct packed {
    logic [ByteFields-1:0][7:0] bytes;
    logic [CntW-1:0]            cnt;
    logic                       last;
  } grp_t;

  // copy engine states
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_COPY = 2'b10
  } eng_state_e;

endpackage

[hdl/lz77td_hist_ram.sv]
// ----------------------------------------------------------------------------
// lz77td_hist_ram
// Simple dual-port history memory: one write port, one read port with a
// registered read. A read of the entry written at the same edge returns the
// old contents.
// ----------------------------------------------------------------------------
module lz77td_hist_ram #(
  parameter int unsigned Aw = 15,
  parameter int unsigned Dw = 8
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [Aw-1:0] waddr_i,
  input  logic [Dw-1:0] wdata_i,
  input  logic          re_i,
  input  logic [Aw-1:0] raddr_i,
  output logic [Dw-1:0] rdata_o
);

  logic [Dw-1:0] mem [2**Aw];
  logic [Dw-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/lz77td_engine.sv]
// ----------------------------------------------------------------------------
// lz77td_engine
// Token intake and copy loop. Reads the history one byte per cycle while
// the group has room, writes every produced byte back at the write pointer,
// forwards a byte read while it is being written, and packs bytes into groups.
// ----------------------------------------------------------------------------
module lz77td_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                is_match_i,
  input  logic [7:0]                          literal_byte_i,
  input  logic [7:0]                          length_code_i,
  input  logic [lz77td_pkg::DistW-1:0]        distance_i,
  output logic                                grp_valid_o,
  input  logic                                grp_take_i,
  output lz77td_pkg::grp_t                    grp_o
);

  localparam int unsigned Aw = lz77td_pkg::HistAw;
  localparam int unsigned Lw = lz77td_pkg::LenW;
  localparam int unsigned Cw = lz77td_pkg::CntW;
  localparam int unsigned Iw = lz77td_pkg::ByteIdxW;

  lz77td_pkg::eng_state_e state_q, state_d;

  logic [Aw-1:0] wp_q, rd_q;
  logic [Lw-1:0] issue_left_q, arrive_left_q;
  logic          rv_q;
  logic          fwd_hit_q;
  lz77td_pkg::byte_t fwd_byte_q;
  lz77td_pkg::byte_t grp_byte_q [lz77td_pkg::ByteFields];
  logic [Cw-1:0] grp_cnt_q;
  logic          grp_last_q;

  logic          accept, lit_accept, match_accept;
  logic          issue;
  logic          we;
  lz77td_pkg::byte_t wdata, rdata, byte_in;
  logic [Lw-1:0] match_len;

  // intake
  assign in_ready_o   = (state_q == lz77td_pkg::S_IDLE) && (grp_cnt_q == '0) && !grp_last_q;
  assign accept       = in_valid_i && in_ready_o;
  assign lit_accept   = accept && !is_match_i;
  assign match_accept = accept && is_match_i;
  assign match_len    = Lw'(length_code_i) + lz77td_pkg::MatchBase;

  // read issue: only when the group has room for the byte in flight too
  assign issue = (state_q == lz77td_pkg::S_COPY) && (issue_left_q != '0) &&
                 ((grp_cnt_q + Cw'(rv_q)) < Cw'(lz77td_pkg::BytesPerResult));

  // returning byte, forwarded when its entry was written during the read
  assign byte_in = fwd_hit_q ? fwd_byte_q : rdata;

  // history write: literal on intake, copied byte on return
  assign we    = lit_accept || rv_q;
  assign wdata = rv_q ? byte_in : literal_byte_i;

  lz77td_hist_ram #(
    .Aw (Aw),
    .Dw (8)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (issue),
    .raddr_i (rd_q),
    .rdata_o (rdata)
  );

  // state sequencing
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lz77td_pkg::S_IDLE: begin
        if (match_accept) state_d = lz77td_pkg::S_COPY;
      end
      lz77td_pkg::S_COPY: begin
        if (rv_q && (arrive_left_q == Lw'(1))) state_d = lz77td_pkg::S_IDLE;
      end
      default: state_d = lz77td_pkg::S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= lz77td_pkg::S_IDLE;
      wp_q          <= '0;
      rd_q          <= '0;
      issue_left_q  <= '0;
      arrive_left_q <= '0;
      rv_q          <= 1'b0;
      fwd_hit_q     <= 1'b0;
      grp_cnt_q     <= '0;
      grp_last_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      rv_q      <= issue;
      fwd_hit_q <= issue && we && (rd_q == wp_q);
      if (we) begin
        wp_q <= wp_q + Aw'(1);
      end
      if (match_accept) begin
        rd_q          <= wp_q - Aw'(distance_i);
        issue_left_q  <= match_len;
        arrive_left_q <= match_len;
      end else if (issue) begin
        rd_q         <= rd_q + Aw'(1);
        issue_left_q <= issue_left_q - Lw'(1);
      end
      if (rv_q) begin
        arrive_left_q <= arrive_left_q - Lw'(1);
      end
      // group fill and hand-off
      if (grp_take_i) begin
        grp_cnt_q  <= '0;
        grp_last_q <= 1'b0;
      end else if (lit_accept) begin
        grp_cnt_q  <= Cw'(1);
        grp_last_q <= 1'b1;
      end else if (rv_q) begin
        grp_cnt_q <= grp_cnt_q + Cw'(1);
        if (arrive_left_q == Lw'(1)) grp_last_q <= 1'b1;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (issue && we) begin
      fwd_byte_q <= wdata;
    end
    if (lit_accept) begin
      grp_byte_q[0] <= literal_byte_i;
    end else if (rv_q) begin
      grp_byte_q[grp_cnt_q[Iw-1:0]] <= byte_in;
    end
  end

  // group out
  assign grp_valid_o = (grp_cnt_q == Cw'(lz77td_pkg::BytesPerResult)) || grp_last_q;
  always_comb begin
    for (int k = 0; k < lz77td_pkg::ByteFields; k++) begin
      grp_o.bytes[k] = grp_byte_q[k];
    end
    grp_o.cnt  = grp_cnt_q;
    grp_o.last = grp_last_q;
  end

  // a returning byte always follows a read issued in the copy state
  a_rv_after_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue |=> rv_q)
    else $error("read issued without returning byte");

  // the group never overfills
  a_grp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_cnt_q <= Cw'(lz77td_pkg::BytesPerResult))
    else $error("byte group overflow");

  // a handed-off group leaves an empty group behind
  a_take_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_take_i |=> (grp_cnt_q == '0) && !grp_last_q)
    else $error("group not cleared after hand-off");

  // a match token starts the copy loop with a full length to issue
  a_match_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    match_accept |=> (state_q == lz77td_pkg::S_COPY) && (issue_left_q >= lz77td_pkg::MatchBase))
    else $error("match did not start copy");

endmodule

[hdl/lz77_token_decoder.sv]
// ----------------------------------------------------------------------------
// lz77_token_decoder
// Top level of the lz77 token decoder: copy engine with its history memory
// and the output register that holds one result beat.
// ----------------------------------------------------------------------------
// Usage
//   Input channel: one token per beat (is_match_i, literal_byte_i,
//   length_code_i, distance_i) under in_valid_i / in_ready_o.
//   Output channel: groups of up to 8 bytes on byte_0_o..byte_7_o with
//   valid_count_o and last_o under out_valid_o / out_ready_i; last_o marks
//   the final beat of a token, unused byte lanes read as zero.
//   A literal is one result beat, held in the engine's group register and
//   then moved to the output register once that register is free.
//   A match copies one byte per cycle through the history memory's single
//   read port while the byte group has room; groups of 8 bytes are handed
//   to the output register as they fill.
//   A new token is taken once the previous token's last group has moved to
//   the output register, so intake overlaps a result still waiting there.
//   When the receiver stalls, the output register holds its beat, the group
//   behind it fills and the copy loop pauses until the register frees.
//   Reset clears the write pointer and all handshake state; the history
//   contents are undefined until written, and no clearing pass is run.
// ----------------------------------------------------------------------------
module lz77_token_decoder (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         is_match_i,
  input  logic [7:0]                   literal_byte_i,
  input  logic [7:0]                   length_code_i,
  input  logic [lz77td_pkg::DistW-1:0] distance_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   byte_0_o,
  output logic [7:0]                   byte_1_o,
  output logic [7:0]                   byte_2_o,
  output logic [7:0]                   byte_3_o,
  output logic [7:0]                   byte_4_o,
  output logic [7:0]                   byte_5_o,
  output logic [7:0]                   byte_6_o,
  output logic [7:0]                   byte_7_o,
  output logic [lz77td_pkg::CntW-1:0]  valid_count_o,
  output logic                         last_o
);

  localparam int unsigned Cw = lz77td_pkg::CntW;

  logic              grp_valid, grp_take;
  lz77td_pkg::grp_t  grp;

  logic              out_valid_q;
  lz77td_pkg::byte_t out_byte_q [lz77td_pkg::ByteFields];
  logic [Cw-1:0]     out_cnt_q;
  logic              out_last_q;

  lz77td_engine u_engine (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .is_match_i     (is_match_i),
    .literal_byte_i (literal_byte_i),
    .length_code_i  (length_code_i),
    .distance_i     (distance_i),
    .grp_valid_o    (grp_valid),
    .grp_take_i     (grp_take),
    .grp_o          (grp)
  );

  // move a finished group when the output register is free or draining
  assign grp_take = grp_valid && (!out_valid_q || out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (grp_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output payload, lanes past the count forced to zero
  always_ff @(posedge clk_i) begin
    if (grp_take) begin
      for (int k = 0; k < lz77td_pkg::ByteFields; k++) begin
        out_byte_q[k] <= (Cw'(k) < grp.cnt) ? grp.bytes[k] : 8'h00;
      end
      out_cnt_q  <= grp.cnt;
      out_last_q <= grp.last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign byte_0_o      = out_byte_q[0];
  assign byte_1_o      = out_byte_q[1];
  assign byte_2_o      = out_byte_q[2];
  assign byte_3_o      = out_byte_q[3];
  assign byte_4_o      = out_byte_q[4];
  assign byte_5_o      = out_byte_q[5];
  assign byte_6_o      = out_byte_q[6];
  assign byte_7_o      = out_byte_q[7];
  assign valid_count_o = out_cnt_q;
  assign last_o        = out_last_q;

endmodule
